@@ rtl/core/efc_pkg.sv @@
// Shared types and constants for the Ethernet frame classifier.
package efc_pkg;

  localparam logic [15:0] ETH2_MIN_TYPE = 16'h05DC;
  localparam logic [15:0] TYPE_IPV4     = 16'h0800;
  localparam logic [15:0] TYPE_ARP      = 16'h0806;
  localparam logic [15:0] TYPE_IPX_A    = 16'h8137;
  localparam logic [15:0] TYPE_IPX_B    = 16'h8138;
  localparam logic [15:0] WORD_RAW      = 16'hFFFF;
  localparam logic [15:0] WORD_SNAP     = 16'hAAAA;
  localparam logic [15:0] ARP_LEN       = 16'd28;
  localparam logic [16:0] HDR_LEN       = 17'd14;

  typedef enum logic [1:0] {
    KIND_ETH2 = 2'd0,
    KIND_RAW  = 2'd1,
    KIND_SNAP = 2'd2,
    KIND_LLC  = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    PL_NONE = 2'd0,
    PL_IPV4 = 2'd1,
    PL_ARP  = 2'd2,
    PL_IPX  = 2'd3
  } payload_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HALT  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0]   frame_number;
    logic [47:0]   dest_mac;
    logic [47:0]   source_mac;
    frame_kind_t   frame_kind;
    payload_kind_t payload_kind;
    logic [16:0]   frame_length;
    logic [15:0]   payload_length;
    logic [31:0]   ip_source;
    logic [31:0]   ip_dest;
    logic          has_ip;
    status_t       status;
  } frame_rec_t;

endpackage

@@ rtl/core/ethernet_frame_classifier_top.sv @@
// Ethernet frame classifier: byte stream in, one record per frame out.
//
// Input channel: one capture byte per word on in_data_byte, with
// in_end_of_stream marking the last byte of the capture. A word is taken
// when push is high and full is low.
// Result channel: one record per frame on the out_ ports, valid while
// empty is low, taken when pop is high.
// Throughput: one byte per cycle while full is low; the parser updates a
// single offset and the header captures each cycle, so bytes stream back
// to back. A frame's record is written into the queue with the byte that
// ends the frame, and shows on the result ports once it heads the queue.
// Records wait in a FIFO_DEPTH-entry queue. full is high while that queue
// is full, so a stalled receiver backs up the byte stream only after
// FIFO_DEPTH records are waiting.
// After an unknown Ethernet II type the block drops all bytes until reset.
// Reset (rst_n low, synchronous) empties the queue, zeroes the offset,
// clears the halt and restarts the frame count at 1.
module ethernet_frame_classifier_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_frame_number,
  output logic [47:0] out_dest_mac,
  output logic [47:0] out_source_mac,
  output logic [1:0]  out_frame_kind,
  output logic [1:0]  out_payload_kind,
  output logic [16:0] out_frame_length,
  output logic [15:0] out_payload_length,
  output logic [31:0] out_ip_source,
  output logic [31:0] out_ip_dest,
  output logic        out_has_ip,
  output logic [1:0]  out_status
);

  logic                take;
  logic                rec_valid;
  efc_pkg::frame_rec_t rec;
  efc_pkg::frame_rec_t head;

  assign take = push && !full;

  efc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .rec_valid     (rec_valid),
    .rec           (rec)
  );

  efc_rec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  assign out_frame_number   = head.frame_number;
  assign out_dest_mac       = head.dest_mac;
  assign out_source_mac     = head.source_mac;
  assign out_frame_kind     = head.frame_kind;
  assign out_payload_kind   = head.payload_kind;
  assign out_frame_length   = head.frame_length;
  assign out_payload_length = head.payload_length;
  assign out_ip_source      = head.ip_source;
  assign out_ip_dest        = head.ip_dest;
  assign out_has_ip         = head.has_ip;
  assign out_status         = head.status;

endmodule

@@ rtl/core/efc_front.sv @@
// Byte parser: tracks the frame offset, captures header fields, builds one record per frame.
module efc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                end_of_stream,
  output logic                rec_valid,
  output efc_pkg::frame_rec_t rec
);

  logic [16:0] off_r, off_nxt;
  logic [47:0] dmac_r, dmac_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] second_r, second_nxt;
  logic [15:0] snap_r, snap_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] ipsrc_r, ipsrc_nxt;
  logic [31:0] ipdst_r, ipdst_nxt;
  logic [31:0] fcnt_r, fcnt_nxt;
  logic        halted_r, halted_nxt;

  logic                  frame_start, accept, eth2_cur, eth2, has_ip;
  logic                  src_on, dst_on, halt_hit, end_known, done, emit;
  logic [16:0]           src_lo, dst_lo, cnt, decl, need, end_val;
  logic [15:0]           plen;
  efc_pkg::payload_kind_t pk_cur, pk;
  efc_pkg::frame_kind_t   kind;
  efc_pkg::status_t       status;

  function automatic efc_pkg::frame_kind_t f_kind(input logic [15:0] tw,
                                                   input logic [15:0] sw);
    efc_pkg::frame_kind_t k;
    if (tw > efc_pkg::ETH2_MIN_TYPE) k = efc_pkg::KIND_ETH2;
    else if (sw == efc_pkg::WORD_RAW) k = efc_pkg::KIND_RAW;
    else if (sw == efc_pkg::WORD_SNAP) k = efc_pkg::KIND_SNAP;
    else k = efc_pkg::KIND_LLC;
    return k;
  endfunction

  function automatic efc_pkg::payload_kind_t f_payload(input logic [15:0] tw,
                                                        input logic [15:0] sw,
                                                        input logic [15:0] snw);
    efc_pkg::payload_kind_t p;
    p = efc_pkg::PL_NONE;
    if (tw > efc_pkg::ETH2_MIN_TYPE) begin
      if (tw == efc_pkg::TYPE_IPV4) p = efc_pkg::PL_IPV4;
      else if (tw == efc_pkg::TYPE_ARP) p = efc_pkg::PL_ARP;
      else if (tw == efc_pkg::TYPE_IPX_A || tw == efc_pkg::TYPE_IPX_B) p = efc_pkg::PL_IPX;
    end else if (sw == efc_pkg::WORD_SNAP && snw == efc_pkg::TYPE_IPV4) begin
      p = efc_pkg::PL_IPV4;
    end
    return p;
  endfunction

  always_comb begin
    accept      = take && !halted_r;
    frame_start = (off_r == '0);

    // per-frame fields start from zero on the first byte of a frame
    dmac_nxt   = frame_start ? '0 : dmac_r;
    smac_nxt   = frame_start ? '0 : smac_r;
    type_nxt   = frame_start ? '0 : type_r;
    second_nxt = frame_start ? '0 : second_r;
    snap_nxt   = frame_start ? '0 : snap_r;
    len_nxt    = frame_start ? '0 : len_r;
    ipsrc_nxt  = frame_start ? '0 : ipsrc_r;
    ipdst_nxt  = frame_start ? '0 : ipdst_r;

    if (off_r < 17'd6) dmac_nxt = {dmac_nxt[39:0], data_byte};
    else if (off_r < 17'd12) smac_nxt = {smac_nxt[39:0], data_byte};
    else if (off_r < 17'd14) type_nxt = {type_nxt[7:0], data_byte};
    else if (off_r < 17'd16) second_nxt = {second_nxt[7:0], data_byte};
    else if (off_r < 17'd18) len_nxt = {len_nxt[7:0], data_byte};
    else if (off_r == 17'd20 || off_r == 17'd21) snap_nxt = {snap_nxt[7:0], data_byte};

    // address windows; header words are settled by byte 26
    eth2_cur = type_r > efc_pkg::ETH2_MIN_TYPE;
    pk_cur   = f_payload(type_r, second_r, snap_r);
    src_on   = 1'b0;
    src_lo   = 17'd26;
    dst_lo   = 17'd30;
    if (eth2_cur && pk_cur == efc_pkg::PL_IPV4) begin
      src_on = 1'b1;
    end else if (eth2_cur && pk_cur == efc_pkg::PL_ARP) begin
      src_on = 1'b1;
      src_lo = 17'd28;
      dst_lo = 17'd38;
    end else if (!eth2_cur && pk_cur == efc_pkg::PL_IPV4) begin
      src_on = 1'b1;
      src_lo = 17'd34;
      dst_lo = 17'd38;
    end
    dst_on = src_on && off_r >= 17'd26 && off_r >= dst_lo && off_r < dst_lo + 17'd4;
    src_on = src_on && off_r >= 17'd26 && off_r >= src_lo && off_r < src_lo + 17'd4;
    if (src_on) ipsrc_nxt = {ipsrc_nxt[23:0], data_byte};
    if (dst_on) ipdst_nxt = {ipdst_nxt[23:0], data_byte};

    // classify on the updated header
    eth2 = type_nxt > efc_pkg::ETH2_MIN_TYPE;
    kind = f_kind(type_nxt, second_nxt);
    pk   = f_payload(type_nxt, second_nxt, snap_nxt);
    if (!eth2) plen = type_nxt;
    else if (pk == efc_pkg::PL_IPV4 || pk == efc_pkg::PL_IPX) plen = len_nxt;
    else if (pk == efc_pkg::PL_ARP) plen = efc_pkg::ARP_LEN;
    else plen = '0;

    if (eth2) begin
      case (pk)
        efc_pkg::PL_IPV4: need = 17'd34;
        efc_pkg::PL_ARP:  need = 17'd42;
        efc_pkg::PL_IPX:  need = 17'd18;
        default:          need = 17'd14;
      endcase
    end else if (kind == efc_pkg::KIND_SNAP) begin
      need = (pk == efc_pkg::PL_IPV4) ? 17'd42 : 17'd22;
    end else begin
      need = 17'd16;
    end

    decl    = efc_pkg::HDR_LEN + {1'b0, plen};
    end_val = (decl > need) ? decl : need;
    cnt     = off_r + 17'd1;

    halt_hit = (cnt == 17'd14) && eth2 && pk == efc_pkg::PL_NONE;
    if (cnt < 17'd14) end_known = 1'b0;
    else if (eth2) end_known = (pk == efc_pkg::PL_ARP) || cnt >= 17'd18;
    else end_known = cnt >= 17'd16 && (second_nxt != efc_pkg::WORD_SNAP || cnt >= 17'd22);
    done = end_known && cnt >= end_val;

    if (halt_hit) status = efc_pkg::ST_HALT;
    else if (done) status = (decl < need) ? efc_pkg::ST_SHORT : efc_pkg::ST_OK;
    else status = efc_pkg::ST_TRUNC;

    emit = accept && (halt_hit || done || end_of_stream);

    has_ip = (pk == efc_pkg::PL_IPV4) || (pk == efc_pkg::PL_ARP);
    rec.frame_number   = fcnt_r;
    rec.dest_mac       = dmac_nxt;
    rec.source_mac     = smac_nxt;
    rec.frame_kind     = kind;
    rec.payload_kind   = pk;
    rec.frame_length   = decl;
    rec.payload_length = plen;
    rec.ip_source      = has_ip ? ipsrc_nxt : '0;
    rec.ip_dest        = has_ip ? ipdst_nxt : '0;
    rec.has_ip         = has_ip;
    rec.status         = status;
    rec_valid          = emit;

    off_nxt    = emit ? '0 : cnt;
    fcnt_nxt   = fcnt_r + 32'd1;
    halted_nxt = halted_r || halt_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      fcnt_r   <= 32'd1;
      halted_r <= 1'b0;
    end else if (accept) begin
      off_r    <= off_nxt;
      halted_r <= halted_nxt;
      if (emit) fcnt_r <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dmac_r   <= dmac_nxt;
      smac_r   <= smac_nxt;
      type_r   <= type_nxt;
      second_r <= second_nxt;
      snap_r   <= snap_nxt;
      len_r    <= len_nxt;
      ipsrc_r  <= ipsrc_nxt;
      ipdst_r  <= ipdst_nxt;
    end
  end

endmodule

@@ rtl/core/efc_rec_fifo.sv @@
// Short record queue between the parser and the result port.
module efc_rec_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  efc_pkg::frame_rec_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output efc_pkg::frame_rec_t rd_data,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  efc_pkg::frame_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_nxt;
      if (do_rd) rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ test/ethernet_frame_classifier_top_tb.sv @@
// Testbench for the Ethernet frame classifier: framed byte streams in, checked records out.
`timescale 1ns / 1ps

module ethernet_frame_classifier_top_tb;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_stream = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_frame_number;
  logic [47:0] out_dest_mac;
  logic [47:0] out_source_mac;
  logic [1:0]  out_frame_kind;
  logic [1:0]  out_payload_kind;
  logic [16:0] out_frame_length;
  logic [15:0] out_payload_length;
  logic [31:0] out_ip_source;
  logic [31:0] out_ip_dest;
  logic        out_has_ip;
  logic [1:0]  out_status;

  ethernet_frame_classifier_top uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_end_of_stream(in_end_of_stream),
    .empty(empty), .pop(pop),
    .out_frame_number(out_frame_number), .out_dest_mac(out_dest_mac),
    .out_source_mac(out_source_mac), .out_frame_kind(out_frame_kind),
    .out_payload_kind(out_payload_kind), .out_frame_length(out_frame_length),
    .out_payload_length(out_payload_length), .out_ip_source(out_ip_source),
    .out_ip_dest(out_ip_dest), .out_has_ip(out_has_ip), .out_status(out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirror, starting from its reset values
  int unsigned frame_pos = 0;
  logic [47:0] dmac_acc = '0;
  logic [47:0] smac_acc = '0;
  logic [15:0] type_acc = '0;
  logic [15:0] word2_acc = '0;
  logic [15:0] snap_acc = '0;
  logic [15:0] iplen_acc = '0;
  logic [31:0] ipsrc_acc = '0;
  logic [31:0] ipdst_acc = '0;
  logic [31:0] frame_count = 32'd1;
  bit          parser_halted = 1'b0;

  efc_pkg::frame_rec_t frame_records_due[$];
  efc_pkg::frame_rec_t head_rec;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          hold_req = 0;
  int unsigned quiet_cycles = 0;
  bit          idling = 1'b1;
  logic [7:0]  hdr [22];

  function automatic bit eth2_now();
    return type_acc > efc_pkg::ETH2_MIN_TYPE;
  endfunction

  function automatic efc_pkg::frame_kind_t kind_now();
    if (eth2_now()) return efc_pkg::KIND_ETH2;
    if (word2_acc == efc_pkg::WORD_RAW) return efc_pkg::KIND_RAW;
    if (word2_acc == efc_pkg::WORD_SNAP) return efc_pkg::KIND_SNAP;
    return efc_pkg::KIND_LLC;
  endfunction

  function automatic efc_pkg::payload_kind_t payload_now();
    if (eth2_now()) begin
      if (type_acc == efc_pkg::TYPE_IPV4) return efc_pkg::PL_IPV4;
      if (type_acc == efc_pkg::TYPE_ARP) return efc_pkg::PL_ARP;
      if (type_acc == efc_pkg::TYPE_IPX_A || type_acc == efc_pkg::TYPE_IPX_B)
        return efc_pkg::PL_IPX;
      return efc_pkg::PL_NONE;
    end
    if (kind_now() == efc_pkg::KIND_SNAP && snap_acc == efc_pkg::TYPE_IPV4)
      return efc_pkg::PL_IPV4;
    return efc_pkg::PL_NONE;
  endfunction

  function automatic logic [15:0] paylen_now();
    if (!eth2_now()) return type_acc;
    case (payload_now())
      efc_pkg::PL_IPV4, efc_pkg::PL_IPX: return iplen_acc;
      efc_pkg::PL_ARP:                   return efc_pkg::ARP_LEN;
      default:                           return 16'd0;
    endcase
  endfunction

  // bytes that must be read before the frame may end
  function automatic int unsigned header_extent();
    if (eth2_now()) begin
      case (payload_now())
        efc_pkg::PL_IPV4: return 34;
        efc_pkg::PL_ARP:  return 42;
        efc_pkg::PL_IPX:  return 18;
        default:          return 14;
      endcase
    end
    if (kind_now() == efc_pkg::KIND_SNAP) return (payload_now() == efc_pkg::PL_IPV4) ? 42 : 22;
    return 16;
  endfunction

  // frame end once it is known after c bytes, 0 while still unknown
  function automatic int unsigned frame_end_at(int unsigned c);
    int unsigned decl;
    int unsigned need;
    if (c < 14) return 0;
    if (eth2_now()) begin
      if (payload_now() == efc_pkg::PL_ARP) return 42;
      if (c < 18) return 0;
    end else begin
      if (c < 16) return 0;
      if (word2_acc == efc_pkg::WORD_SNAP && c < 22) return 0;
    end
    decl = 32'(paylen_now()) + 14;
    need = header_extent();
    return (decl > need) ? decl : need;
  endfunction

  function automatic void record_frame(efc_pkg::status_t st);
    efc_pkg::frame_rec_t r;
    efc_pkg::payload_kind_t pk;
    logic [15:0] pl;
    pk = payload_now();
    pl = paylen_now();
    r.frame_number   = frame_count;
    r.dest_mac       = dmac_acc;
    r.source_mac     = smac_acc;
    r.frame_kind     = kind_now();
    r.payload_kind   = pk;
    r.frame_length   = efc_pkg::HDR_LEN + {1'b0, pl};
    r.payload_length = pl;
    r.has_ip         = (pk == efc_pkg::PL_IPV4 || pk == efc_pkg::PL_ARP);
    r.ip_source      = r.has_ip ? ipsrc_acc : 32'd0;
    r.ip_dest        = r.has_ip ? ipdst_acc : 32'd0;
    r.status         = st;
    frame_records_due.push_back(r);
    frame_count++;
  endfunction

  function automatic void classify_byte(logic [7:0] b, logic eos);
    int unsigned o;
    int unsigned c;
    int unsigned fe;
    int unsigned src;
    int unsigned dst;
    efc_pkg::payload_kind_t pk;
    if (parser_halted) return;
    o = frame_pos;
    if (o == 0) begin
      dmac_acc = '0; smac_acc = '0; type_acc = '0; word2_acc = '0;
      snap_acc = '0; iplen_acc = '0; ipsrc_acc = '0; ipdst_acc = '0;
    end
    if (o < 6) dmac_acc = {dmac_acc[39:0], b};
    else if (o < 12) smac_acc = {smac_acc[39:0], b};
    else if (o < 14) type_acc = {type_acc[7:0], b};
    else if (o < 16) word2_acc = {word2_acc[7:0], b};
    else if (o < 18) iplen_acc = {iplen_acc[7:0], b};
    else if (o == 20 || o == 21) snap_acc = {snap_acc[7:0], b};
    if (o >= 26) begin
      pk = payload_now();
      src = 0;
      dst = 0;
      // address offsets: IPv4 header, ARP sender/target, IPv4 behind SNAP
      if (eth2_now() && pk == efc_pkg::PL_IPV4) begin src = 26; dst = 30; end
      else if (eth2_now() && pk == efc_pkg::PL_ARP) begin src = 28; dst = 38; end
      else if (!eth2_now() && pk == efc_pkg::PL_IPV4) begin src = 34; dst = 38; end
      if (src != 0 && o >= src && o < src + 4) ipsrc_acc = {ipsrc_acc[23:0], b};
      if (dst != 0 && o >= dst && o < dst + 4) ipdst_acc = {ipdst_acc[23:0], b};
    end
    c = o + 1;
    frame_pos = c;
    if (c == 14 && eth2_now() && payload_now() == efc_pkg::PL_NONE) begin
      record_frame(efc_pkg::ST_HALT);
      parser_halted = 1'b1;
      frame_pos = 0;
      return;
    end
    fe = frame_end_at(c);
    if (fe != 0 && c >= fe) begin
      record_frame((32'(paylen_now()) + 14 < header_extent()) ? efc_pkg::ST_SHORT
                                                               : efc_pkg::ST_OK);
      frame_pos = 0;
      return;
    end
    if (eos) begin
      record_frame(efc_pkg::ST_TRUNC);
      frame_pos = 0;
    end
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (frame_records_due.size() == 0) begin
        $display("%0t: record %0h arrived, none expected", $time, out_frame_number);
        mismatches++;
      end else begin
        head_rec = frame_records_due.pop_front();
        check_field("frame_number", 64'(head_rec.frame_number), 64'(out_frame_number));
        check_field("dest_mac", 64'(head_rec.dest_mac), 64'(out_dest_mac));
        check_field("source_mac", 64'(head_rec.source_mac), 64'(out_source_mac));
        check_field("frame_kind", 64'(head_rec.frame_kind), 64'(out_frame_kind));
        check_field("payload_kind", 64'(head_rec.payload_kind), 64'(out_payload_kind));
        check_field("frame_length", 64'(head_rec.frame_length), 64'(out_frame_length));
        check_field("payload_length", 64'(head_rec.payload_length),
                    64'(out_payload_length));
        check_field("ip_source", 64'(head_rec.ip_source), 64'(out_ip_source));
        check_field("ip_dest", 64'(head_rec.ip_dest), 64'(out_ip_dest));
        check_field("has_ip", 64'(head_rec.has_ip), 64'(out_has_ip));
        check_field("status", 64'(head_rec.status), 64'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[ethernet_frame_classifier_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // record receiver: random stalls, plus long holds on request
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idling && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // full only moves on the rising edge, so the falling edge shows what the next edge sees
  task automatic send_byte(input logic [7:0] b, input logic eos);
    bit taken;
    if (idling && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= eos;
    do begin
      @(negedge clk);
      taken = !full;
      if (taken) begin
        classify_byte(b, eos);
        bytes_sent++;
      end
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic make_header(input logic [15:0] ty, input logic [15:0] w2,
                             input logic [15:0] lw, input logic [15:0] sn);
    for (int i = 0; i < 22; i++) hdr[i] = 8'($urandom);
    {hdr[12], hdr[13]} = ty;
    {hdr[14], hdr[15]} = w2;
    {hdr[16], hdr[17]} = lw;
    {hdr[20], hdr[21]} = sn;
  endtask

  // sends header bytes then filler until the parser closes the frame;
  // end of stream goes on byte index cut, fill < 0 means random filler
  task automatic send_frame(input int cut, input int fill);
    int k;
    logic [7:0] b;
    k = 0;
    do begin
      if (k < 22) b = hdr[k];
      else if (fill < 0) b = 8'($urandom);
      else b = fill[7:0];
      send_byte(b, k == cut);
      k++;
    end while (frame_pos != 0);
  endtask

  task automatic test_ethernet2_payloads();
    make_header(efc_pkg::TYPE_IPV4, 16'($urandom), 16'd20, 16'($urandom));
    for (int i = 0; i < 12; i++) hdr[i] = 8'hFF;
    send_frame(-1, 255);
    make_header(efc_pkg::TYPE_IPV4, 16'($urandom), 16'd0, 16'($urandom));
    for (int i = 0; i < 12; i++) hdr[i] = 8'h00;
    send_frame(-1, 0);
    make_header(efc_pkg::TYPE_IPV4, 16'($urandom), 16'd46, 16'($urandom));
    send_frame(-1, -1);
    make_header(efc_pkg::TYPE_ARP, 16'($urandom), 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    make_header(efc_pkg::TYPE_IPX_A, 16'($urandom), 16'd4, 16'($urandom));
    send_frame(-1, -1);
    make_header(efc_pkg::TYPE_IPX_B, 16'($urandom), 16'd3, 16'($urandom));
    send_frame(-1, -1);
    make_header(efc_pkg::TYPE_IPX_A, 16'($urandom), 16'd30, 16'($urandom));
    send_frame(-1, -1);
  endtask

  task automatic test_8023_kinds();
    make_header(16'd0, efc_pkg::WORD_RAW, 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    make_header(16'd2, efc_pkg::WORD_RAW, 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    make_header(16'd16, 16'h4242, 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    make_header(16'd8, efc_pkg::WORD_SNAP, 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    make_header(16'd28, efc_pkg::WORD_SNAP, 16'($urandom), efc_pkg::TYPE_IPV4);
    send_frame(-1, -1);
    make_header(16'd60, efc_pkg::WORD_SNAP, 16'($urandom), efc_pkg::TYPE_IPV4);
    send_frame(-1, -1);
    // largest 802.3 length, cut short
    make_header(efc_pkg::ETH2_MIN_TYPE, 16'h0303, 16'($urandom), 16'($urandom));
    send_frame(40, -1);
  endtask

  task automatic test_stream_end();
    // end of stream on the last byte of a frame is a normal end
    make_header(efc_pkg::TYPE_ARP, 16'($urandom), 16'($urandom), 16'($urandom));
    send_frame(41, -1);
    make_header(16'd0, 16'h0606, 16'($urandom), 16'($urandom));
    send_frame(15, -1);
    make_header(16'($urandom_range(0, 40)), 16'($urandom), 16'($urandom), 16'($urandom));
    send_frame(0, -1);
    // largest declared length, cut short
    make_header(efc_pkg::TYPE_IPV4, 16'($urandom), 16'hFFFF, 16'($urandom));
    send_frame(60, -1);
    make_header(efc_pkg::TYPE_IPX_B, 16'($urandom), 16'hFFFF, 16'($urandom));
    send_frame(17, -1);
    make_header(16'd40, efc_pkg::WORD_SNAP, 16'($urandom), efc_pkg::TYPE_IPV4);
    send_frame(20, -1);
    make_header(efc_pkg::TYPE_IPV4, 16'($urandom), 16'd40, 16'($urandom));
    send_frame(12, -1);
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    repeat (10) begin
      make_header(16'($urandom_range(0, 6)), 16'h5A5A, 16'($urandom), 16'($urandom));
      send_frame(-1, -1);
    end
  endtask

  task automatic test_random_frames(input int n_bytes);
    int stop_at;
    int frames;
    int cat;
    int cut;
    logic [15:0] ty;
    logic [15:0] w2;
    logic [15:0] lw;
    logic [15:0] sn;
    stop_at = bytes_sent + n_bytes;
    frames = 0;
    while (bytes_sent < stop_at || frames < n_bytes / 25) begin
      cat = $urandom_range(0, 19);
      ty = efc_pkg::TYPE_IPV4;
      w2 = 16'($urandom);
      lw = 16'($urandom_range(0, 64));
      sn = 16'($urandom);
      cut = -1;
      if (cat < 6) begin
        if ($urandom_range(0, 9) == 0) begin lw = 16'($urandom); cut = $urandom_range(0, 60); end
      end else if (cat < 9) begin
        ty = efc_pkg::TYPE_ARP;
      end else if (cat < 11) begin
        ty = (cat == 9) ? efc_pkg::TYPE_IPX_A : efc_pkg::TYPE_IPX_B;
        if ($urandom_range(0, 9) == 0) begin lw = 16'($urandom); cut = $urandom_range(0, 40); end
      end else if (cat < 13) begin
        ty = 16'($urandom_range(0, 48));
        w2 = efc_pkg::WORD_RAW;
      end else if (cat < 16) begin
        ty = 16'($urandom_range(0, 48));
        w2 = efc_pkg::WORD_SNAP;
        if ($urandom_range(0, 1) == 1) sn = efc_pkg::TYPE_IPV4;
      end else if (cat < 18) begin
        ty = 16'($urandom_range(0, 48));
      end else begin
        // noise: any 802.3 length, long ones cut off early
        ty = 16'($urandom_range(0, efc_pkg::ETH2_MIN_TYPE));
        lw = 16'($urandom);
        if (ty > 64) cut = $urandom_range(0, 80);
      end
      if (cut < 0 && $urandom_range(0, 7) == 0) cut = $urandom_range(0, 60);
      make_header(ty, w2, lw, sn);
      send_frame(cut, -1);
      frames++;
    end
  endtask

  // lowest unknown type; the block stays halted for the rest of the run
  task automatic test_unknown_type();
    make_header(efc_pkg::ETH2_MIN_TYPE + 16'd1, 16'($urandom), 16'($urandom), 16'($urandom));
    send_frame(-1, -1);
    repeat (16) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_ethernet2_payloads();
    test_8023_kinds();
    test_stream_end();
    test_backpressure();
    test_random_frames(170);
    idling = 1'b0;
    test_random_frames(80);
    test_unknown_type();
    push <= 1'b0;
    while (frame_records_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ethernet_frame_classifier_top] OK");
    end else begin
      $display("[ethernet_frame_classifier_top] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/efc_pkg.sv
rtl/core/efc_front.sv
rtl/core/efc_rec_fifo.sv
rtl/core/ethernet_frame_classifier_top.sv
test/ethernet_frame_classifier_top_tb.sv
